// File: sv/aetc_pkg.sv
// ----------------------------------------------------------------------------
// Accept-Encoding token check package
// Shared payload types, per-header state and the codes used by the byte
// parser of the zstd offer checker.
// ----------------------------------------------------------------------------
package aetc_pkg;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} aetc_hdr_t;

	typedef struct packed {
		logic accepted;
		logic zero_q_rejected;
	} aetc_res_t;

	localparam logic [3:0] PH_SEARCH = 4'd0;
	localparam logic [3:0] PH_AFTER  = 4'd1;
	localparam logic [3:0] PH_SEMI   = 4'd2;
	localparam logic [3:0] PH_Q      = 4'd3;
	localparam logic [3:0] PH_EQ     = 4'd4;
	localparam logic [3:0] PH_ZERO   = 4'd5;
	localparam logic [3:0] PH_DOT    = 4'd6;
	localparam logic [3:0] PH_D1     = 4'd7;
	localparam logic [3:0] PH_D2     = 4'd8;
	localparam logic [3:0] PH_D3     = 4'd9;

	localparam logic [1:0] V_NONE   = 2'd0;
	localparam logic [1:0] V_ACCEPT = 2'd1;
	localparam logic [1:0] V_REFUSE = 2'd2;

	localparam logic [2:0] TOKEN_LEN = 3'd4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [2:0] match_count;
		logic       prev_is_delimiter;
		logic [3:0] qvalue_phase;
		logic       verdict_done;
		logic [1:0] verdict_value;
	} aetc_state_t;

	localparam aetc_state_t STATE_RESET = '{
		match_count:       3'd0,
		prev_is_delimiter: 1'b1,
		qvalue_phase:      PH_SEARCH,
		verdict_done:      1'b0,
		verdict_value:     V_NONE
	};

	function automatic logic [7:0] token_letter(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0:    ch = 8'h7A;
			2'd1:    ch = 8'h73;
			2'd2:    ch = 8'h74;
			default: ch = 8'h64;
		endcase
		return ch;
	endfunction

endpackage

// File: sv/aetc_if.sv
// ----------------------------------------------------------------------------
// Accept-Encoding token check channels
// Valid/ready channels for header bytes and for verdicts.
// ----------------------------------------------------------------------------
interface aetc_hdr_if;
	import aetc_pkg::*;

	logic      valid;
	logic      ready;
	aetc_hdr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aetc_res_if;
	import aetc_pkg::*;

	logic      valid;
	logic      ready;
	aetc_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/aetc_step.sv
// ----------------------------------------------------------------------------
// Accept-Encoding token check byte step
// Next-state logic for one header byte: token search, weight parse and the
// header-end decision.
// ----------------------------------------------------------------------------
module aetc_step (
	input  aetc_pkg::aetc_state_t cur,
	input  aetc_pkg::aetc_hdr_t   item,
	output aetc_pkg::aetc_state_t nxt,
	output aetc_pkg::aetc_res_t   res
);
	import aetc_pkg::*;

	logic [7:0]  b;
	logic [7:0]  lower;
	logic        is_digit;
	aetc_state_t st;
	aetc_state_t fin;

	assign b        = item.header_byte;
	assign lower    = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

	always_comb begin
		st = cur;
		if (!cur.verdict_done) begin
			case (cur.qvalue_phase)
				PH_AFTER: begin
					if (b == CH_SPACE) begin
						st.qvalue_phase = PH_SEMI;
					end else if (b == CH_SEMI) begin
						st.qvalue_phase = PH_Q;
					end else if (b == CH_COMMA) begin
						st.verdict_done  = 1'b1;
						st.verdict_value = V_ACCEPT;
					end else begin
						st.qvalue_phase      = PH_SEARCH;
						st.match_count       = 3'd0;
						st.prev_is_delimiter = 1'b0;
					end
				end
				PH_SEMI, PH_Q, PH_EQ, PH_ZERO: begin
					if (b != CH_SPACE) begin
						if (cur.qvalue_phase == PH_SEMI && b == CH_SEMI) begin
							st.qvalue_phase = PH_Q;
						end else if (cur.qvalue_phase == PH_Q && b == CH_Q) begin
							st.qvalue_phase = PH_EQ;
						end else if (cur.qvalue_phase == PH_EQ && b == CH_EQ) begin
							st.qvalue_phase = PH_ZERO;
						end else if (cur.qvalue_phase == PH_ZERO && b == CH_ZERO) begin
							st.qvalue_phase = PH_DOT;
						end else begin
							st.verdict_done  = 1'b1;
							st.verdict_value = V_ACCEPT;
						end
					end
				end
				PH_DOT: begin
					if (b == CH_DOT) begin
						st.qvalue_phase = PH_D1;
					end else begin
						st.verdict_done  = 1'b1;
						st.verdict_value = V_REFUSE;
					end
				end
				PH_D1, PH_D2, PH_D3: begin
					if (!is_digit) begin
						st.verdict_done  = 1'b1;
						st.verdict_value = V_REFUSE;
					end else if (b != CH_ZERO) begin
						st.verdict_done  = 1'b1;
						st.verdict_value = V_ACCEPT;
					end else if (cur.qvalue_phase == PH_D3) begin
						st.verdict_done  = 1'b1;
						st.verdict_value = V_REFUSE;
					end else begin
						st.qvalue_phase = cur.qvalue_phase + 4'd1;
					end
				end
				default: begin
					st.qvalue_phase = PH_SEARCH;
					if (cur.match_count == 3'd0) begin
						if (cur.prev_is_delimiter && lower == token_letter(2'd0)) begin
							st.match_count = 3'd1;
						end
					end else if (cur.match_count < TOKEN_LEN &&
						lower == token_letter(cur.match_count[1:0])) begin
						if (cur.match_count + 3'd1 == TOKEN_LEN) begin
							st.match_count  = 3'd0;
							st.qvalue_phase = PH_AFTER;
						end else begin
							st.match_count = cur.match_count + 3'd1;
						end
					end else begin
						st.match_count = 3'd0;
					end
					st.prev_is_delimiter = (b == CH_COMMA) || (b == CH_SPACE);
				end
			endcase
		end

		// The end of the header acts as one more comma.
		fin = st;
		if (!fin.verdict_done) begin
			if (fin.qvalue_phase >= PH_AFTER && fin.qvalue_phase <= PH_ZERO) begin
				fin.verdict_done  = 1'b1;
				fin.verdict_value = V_ACCEPT;
			end else if (fin.qvalue_phase >= PH_DOT && fin.qvalue_phase <= PH_D3) begin
				fin.verdict_done  = 1'b1;
				fin.verdict_value = V_REFUSE;
			end
		end
		res.accepted        = fin.verdict_done && (fin.verdict_value == V_ACCEPT);
		res.zero_q_rejected = fin.verdict_done && (fin.verdict_value == V_REFUSE);
	end

	always_comb begin
		nxt = item.last_byte ? STATE_RESET : st;
	end

endmodule

// File: sv/accept_encoding_token_check.sv
// ----------------------------------------------------------------------------
// Accept-Encoding token check
// Checks whether an Accept-Encoding header value offers zstd with a nonzero
// or absent weight.
// ----------------------------------------------------------------------------
// The hdr channel carries one byte of the header value per transaction, with
// last_byte set on the final byte. Exactly one transaction leaves on the res
// channel for each header, after its final byte: accepted is set when the
// first delimited zstd token carries a nonzero or absent q value, and
// zero_q_rejected when that token carries a zero q value. Both are clear when
// no delimited token was found.
// A byte enters an input register and is then folded into the per-header
// state, where the verdict of a final byte is registered too; the verdict
// register then offers it on the res channel. One byte is taken every cycle
// while hdr.ready is high. While the receiver stalls with a verdict pending,
// the block keeps taking bytes until a second final byte reaches the input
// register, and then holds hdr.ready low. Reset clears both registers and
// returns the parser to the start of a header; each final byte does the same
// for the next header.
// ----------------------------------------------------------------------------
module accept_encoding_token_check (
	input  logic              clk,
	input  logic              arst_n,
	aetc_hdr_if.sink          hdr,
	aetc_res_if.source        res
);
	import aetc_pkg::*;

	logic        valid_s1;
	aetc_hdr_t   item_s1;
	aetc_state_t state_q;
	aetc_state_t state_nxt;
	aetc_res_t   res_nxt;
	logic        res_valid_q;
	aetc_res_t   res_q;
	logic        res_free;
	logic        advance_s1;

	aetc_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign res_free   = !res_valid_q || res.ready;
	assign advance_s1 = valid_s1 && (!item_s1.last_byte || res_free);
	assign hdr.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			item_s1 <= hdr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance_s1 && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && advance_s1 && item_s1.last_byte) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Accept-Encoding token check testbench
// Streams header values into the block one byte per transaction, with random
// gaps on the sender and random stalls on the receiver. A scoreboard keeps its
// own parser state, predicts the verdict of each header on its final byte and
// compares it with the verdict that the block returns.
// ----------------------------------------------------------------------------
import aetc_pkg::*;

typedef logic [7:0] byte_q_t[$];

localparam logic [3:0][7:0] TOKEN_TEXT = "zstd";

class zstd_offer_board;
	aetc_state_t st;
	aetc_res_t awaited[$];
	int unsigned failures;
	int unsigned verdicts;

	function new();
		st = STATE_RESET;
		failures = 0;
		verdicts = 0;
	endfunction

	function void report(string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	function void settle(logic [1:0] v);
		st.verdict_done = 1'b1;
		st.verdict_value = v;
	endfunction

	function void after_spaces(logic [7:0] b, logic [7:0] want, logic [3:0] nxt);
		if (b == CH_SPACE)
			return;
		if (b == want)
			st.qvalue_phase = nxt;
		else
			settle(V_ACCEPT);
	endfunction

	function void decimal_place(logic [7:0] b, logic [3:0] nxt);
		if (b < CH_ZERO || b > CH_NINE)
			settle(V_REFUSE);
		else if (b != CH_ZERO)
			settle(V_ACCEPT);
		else if (nxt == PH_SEARCH)
			settle(V_REFUSE);
		else
			st.qvalue_phase = nxt;
	endfunction

	function void scan_byte(logic [7:0] b);
		logic [7:0] folded;
		folded = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
		if (st.match_count == 3'd0) begin
			if (st.prev_is_delimiter && folded == TOKEN_TEXT[3])
				st.match_count = 3'd1;
		end else if (st.match_count < TOKEN_LEN && folded == TOKEN_TEXT[3 - st.match_count]) begin
			st.match_count = st.match_count + 3'd1;
			if (st.match_count == TOKEN_LEN) begin
				st.match_count = 3'd0;
				st.qvalue_phase = PH_AFTER;
			end
		end else begin
			st.match_count = 3'd0;
		end
		st.prev_is_delimiter = (b == CH_COMMA || b == CH_SPACE);
	endfunction

	function void note_byte(aetc_hdr_t item);
		aetc_res_t want;
		logic [7:0] b;
		b = item.header_byte;
		if (!st.verdict_done) begin
			case (st.qvalue_phase)
				PH_AFTER: begin
					if (b == CH_COMMA || b == CH_SPACE || b == CH_SEMI) begin
						st.qvalue_phase = PH_SEMI;
						after_spaces(b, CH_SEMI, PH_Q);
					end else begin
						st.qvalue_phase = PH_SEARCH;
						st.match_count = 3'd0;
						st.prev_is_delimiter = 1'b0;
					end
				end
				PH_SEMI: after_spaces(b, CH_SEMI, PH_Q);
				PH_Q:    after_spaces(b, CH_Q, PH_EQ);
				PH_EQ:   after_spaces(b, CH_EQ, PH_ZERO);
				PH_ZERO: after_spaces(b, CH_ZERO, PH_DOT);
				PH_DOT: begin
					if (b == CH_DOT)
						st.qvalue_phase = PH_D1;
					else
						settle(V_REFUSE);
				end
				PH_D1: decimal_place(b, PH_D2);
				PH_D2: decimal_place(b, PH_D3);
				PH_D3: decimal_place(b, PH_SEARCH);
				default: begin
					st.qvalue_phase = PH_SEARCH;
					scan_byte(b);
				end
			endcase
		end
		if (!item.last_byte)
			return;
		if (!st.verdict_done) begin
			if (st.qvalue_phase >= PH_AFTER && st.qvalue_phase <= PH_ZERO)
				settle(V_ACCEPT);
			else if (st.qvalue_phase >= PH_DOT && st.qvalue_phase <= PH_D3)
				settle(V_REFUSE);
		end
		want.accepted = st.verdict_done && st.verdict_value == V_ACCEPT;
		want.zero_q_rejected = st.verdict_done && st.verdict_value == V_REFUSE;
		awaited.push_back(want);
		st = STATE_RESET;
	endfunction

	function void check_verdict(aetc_res_t got);
		aetc_res_t want;
		verdicts++;
		if (awaited.size() == 0) begin
			report($sformatf(
				"verdict %0d arrived with none outstanding: accepted=%0b zero_q_rejected=%0b",
				verdicts, got.accepted, got.zero_q_rejected));
			return;
		end
		want = awaited.pop_front();
		if (got.accepted !== want.accepted)
			report($sformatf("verdict %0d accepted: expected %0b, actual %0b",
				verdicts, want.accepted, got.accepted));
		if (got.zero_q_rejected !== want.zero_q_rejected)
			report($sformatf("verdict %0d zero_q_rejected: expected %0b, actual %0b",
				verdicts, want.zero_q_rejected, got.zero_q_rejected));
	endfunction
endclass

module testbench;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_BYTES = 330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;

	aetc_hdr_if hdr_ch ();
	aetc_res_if res_ch ();

	zstd_offer_board board = new();

	accept_encoding_token_check dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void push_text(ref byte_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic void push_token(ref byte_q_t q);
		logic [7:0] ch;
		for (int i = 3; i >= 0; i--) begin
			ch = TOKEN_TEXT[i];
			q.push_back($urandom_range(0, 1) ? ch - CASE_OFS : ch);
		end
	endfunction

	function automatic void push_spaces(ref byte_q_t q);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) q.push_back(CH_SPACE);
	endfunction

	function automatic logic [7:0] random_place();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return CH_ZERO;
		if (pick < 9)
			return CH_ZERO + 8'($urandom_range(1, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic byte_q_t random_header();
		string fillers[7] = '{"gzip", "br", "zst", "xzstd", "zstdd", "*;q=0", "identity"};
		string seps[5] = '{",", " ", ", ", ";", " ,"};
		byte_q_t q;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		if ($urandom_range(0, 2) == 0) begin
			push_text(q, fillers[$urandom_range(0, 6)]);
			push_text(q, seps[$urandom_range(0, 4)]);
		end
		push_token(q);
		case ($urandom_range(0, 7))
			0: ;
			1: begin
				push_text(q, seps[$urandom_range(0, 4)]);
				push_text(q, fillers[$urandom_range(0, 6)]);
			end
			default: begin
				push_spaces(q);
				q.push_back(CH_SEMI);
				push_spaces(q);
				q.push_back($urandom_range(0, 7) == 0 ? CH_Q - CASE_OFS : CH_Q);
				push_spaces(q);
				q.push_back(CH_EQ);
				push_spaces(q);
				if ($urandom_range(0, 4) != 0) begin
					q.push_back(CH_ZERO);
					if ($urandom_range(0, 3) != 0) begin
						q.push_back(CH_DOT);
						repeat ($urandom_range(0, 4)) q.push_back(random_place());
					end else if ($urandom_range(0, 1)) begin
						q.push_back(8'($urandom_range(0, 255)));
					end
				end else begin
					q.push_back(random_place());
				end
			end
		endcase
		if ($urandom_range(0, 2) == 0) begin
			push_text(q, seps[$urandom_range(0, 4)]);
			if ($urandom_range(0, 1))
				push_token(q);
			else
				push_text(q, fillers[$urandom_range(0, 6)]);
		end
		if ($urandom_range(0, 7) == 0)
			q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
		return q;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		aetc_hdr_t item;
		item.header_byte = b;
		item.last_byte = lst;
		while (!(bytes_sent >= 150 && bytes_sent < 260) && $urandom_range(0, 99) < 35) begin
			hdr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hdr_ch.valid <= 1'b1;
		hdr_ch.data <= item;
		do
			@(posedge clk);
		while (!hdr_ch.ready);
		board.note_byte(item);
		bytes_sent++;
	endtask

	task automatic send_header(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_ch.valid && res_ch.ready)
					board.check_verdict(res_ch.data);
				res_ch.ready <= (board.verdicts >= 15 && board.verdicts < 30)
					|| $urandom_range(0, 99) >= 35;
			end
		end
	end

	initial begin
		string directed[11] = '{"zstd", "ZsTd;q=0", "zstd ; q = 0.000", "zstd;q=0.001",
			"zstd;q=0x", "zstd;q=0.a", "zstd;Q=0", "br,zstd;q=1", "xzstd",
			"zstdx, zstd;q=0.", "zstd;q=0.0000,zstd"};
		byte_q_t q;
		int unsigned random_start;
		hdr_ch.valid <= 1'b0;
		hdr_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			q = {};
			push_text(q, directed[i]);
			send_header(q);
		end
		q = {8'h00, 8'hFF};
		send_header(q);
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES)
			send_header(random_header());
		hdr_ch.valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
